// ===== rtl/art_pkg.sv =====
package art_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_BITS = 16;
	localparam int IDX_BITS = $clog2(TABLE_DEPTH);

	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_LOOKUP = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_LINK_FAIL = 3'd3;
	localparam logic [2:0] REQ_RAISE_SEQ = 3'd4;

	localparam logic [1:0] FLAG_VALID = 2'd0;
	localparam logic [1:0] FLAG_INVALID = 2'd1;
	localparam logic [1:0] FLAG_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [15:0] dest_addr;
		logic [31:0] seq_num;
		logic [7:0] hop_count;
		logic [1:0] route_flag;
		logic route_state;
		logic [15:0] next_hop;
	} req_t;

	typedef struct packed {
		logic hit;
		logic updated;
		logic table_full;
		logic [15:0] dest_addr_out;
		logic [15:0] next_hop_out;
		logic [31:0] seq_num_out;
		logic [7:0] hop_count_out;
		logic [1:0] route_flag_out;
		logic route_state_out;
		logic last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic do_op;
		logic scan_step;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_scan;
	} sts_t;

endpackage

// ===== rtl/art_datapath.sv =====
module art_datapath import art_pkg::*; (
	input logic clk,
	input logic arst_n,
	input req_t req,
	input cmd_t cmd,
	output sts_t sts,
	output logic strobe,
	output rsp_t rsp
);

	logic [TABLE_DEPTH-1:0] used_q;
	logic [ADDR_BITS-1:0] dest_q [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] nh_q [TABLE_DEPTH];
	logic [31:0] seq_q [TABLE_DEPTH];
	logic [7:0] hops_q [TABLE_DEPTH];
	logic [1:0] flag_q [TABLE_DEPTH];
	logic st_q [TABLE_DEPTH];

	req_t r_q;
	logic [IDX_BITS-1:0] idx_q;
	logic any_q;

	logic [ADDR_BITS-1:0] dkey, nkey;
	logic [TABLE_DEPTH-1:0] match, free, fail_m;
	logic found, has_free, later;
	logic [IDX_BITS-1:0] midx, fidx;
	logic ovw;
	logic [8:0] hops_p1;
	logic cur_match, last_slot;
	logic strobe_d;
	rsp_t rsp_d;

	assign dkey = r_q.dest_addr[ADDR_BITS-1:0];
	assign nkey = r_q.next_hop[ADDR_BITS-1:0];

	always_comb begin
		found = 1'b0;
		has_free = 1'b0;
		midx = '0;
		fidx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			match[i] = used_q[i] && dest_q[i] == dkey;
			free[i] = !used_q[i];
			if (match[i]) begin
				found = 1'b1;
				midx = IDX_BITS'(i);
			end
			if (free[i]) begin
				has_free = 1'b1;
				fidx = IDX_BITS'(i);
			end
		end
	end

	// routes through the failed neighbor; later marks a hit beyond the current slot
	always_comb begin
		later = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			fail_m[i] = used_q[i] && nh_q[i] == nkey && flag_q[i] == FLAG_VALID;
			if (fail_m[i] && IDX_BITS'(i) > idx_q) later = 1'b1;
		end
	end

	assign hops_p1 = {1'b0, r_q.hop_count} + 9'd1;
	assign ovw = flag_q[midx] != FLAG_VALID || seq_q[midx] < r_q.seq_num
		|| (seq_q[midx] == r_q.seq_num && {1'b0, hops_q[midx]} > hops_p1);
	assign cur_match = fail_m[idx_q];
	assign last_slot = idx_q == IDX_BITS'(TABLE_DEPTH - 1);
	assign sts.scan_done = last_slot;
	assign sts.is_scan = r_q.req_type == REQ_LINK_FAIL;

	function automatic rsp_t none_rsp();
		rsp_t o;
		o = '0;
		o.route_flag_out = FLAG_UNKNOWN;
		o.last = 1'b1;
		return o;
	endfunction

	function automatic rsp_t slot_rsp(logic [ADDR_BITS-1:0] d, logic [ADDR_BITS-1:0] n,
		logic [31:0] s, logic [7:0] h, logic [1:0] f, logic t, logic ht, logic up, logic l);
		rsp_t o;
		o.hit = ht;
		o.updated = up;
		o.table_full = 1'b0;
		o.dest_addr_out = 16'(d);
		o.next_hop_out = 16'(n);
		o.seq_num_out = s;
		o.hop_count_out = h;
		o.route_flag_out = f;
		o.route_state_out = t;
		o.last = l;
		return o;
	endfunction

	always_comb begin
		strobe_d = 1'b0;
		rsp_d = none_rsp();
		if (cmd.do_op) begin
			strobe_d = 1'b1;
			case (r_q.req_type)
				REQ_INSERT: begin
					if (found) begin
						if (ovw) begin
							rsp_d = slot_rsp(dest_q[midx], nkey, r_q.seq_num,
								r_q.hop_count, r_q.route_flag, r_q.route_state,
								1'b1, 1'b1, 1'b1);
						end else begin
							rsp_d = slot_rsp(dest_q[midx], nh_q[midx], seq_q[midx],
								hops_q[midx], flag_q[midx], st_q[midx],
								1'b1, 1'b0, 1'b1);
						end
					end else if (has_free) begin
						rsp_d = slot_rsp(dkey, nkey, r_q.seq_num, r_q.hop_count,
							r_q.route_flag, r_q.route_state, 1'b0, 1'b1, 1'b1);
					end else begin
						rsp_d.table_full = 1'b1;
					end
				end
				REQ_LOOKUP, REQ_REMOVE: begin
					if (found) begin
						rsp_d = slot_rsp(dest_q[midx], nh_q[midx], seq_q[midx],
							hops_q[midx], flag_q[midx], st_q[midx], 1'b1, 1'b0, 1'b1);
					end
				end
				REQ_RAISE_SEQ: begin
					if (found) begin
						rsp_d = slot_rsp(dest_q[midx], nh_q[midx],
							(seq_q[midx] < r_q.seq_num) ? r_q.seq_num : seq_q[midx],
							hops_q[midx], flag_q[midx], st_q[midx], 1'b1, 1'b0, 1'b1);
					end
				end
				default: ;
			endcase
		end
		if (cmd.scan_step) begin
			if (cur_match) begin
				strobe_d = 1'b1;
				rsp_d = slot_rsp(dest_q[idx_q], nh_q[idx_q], seq_q[idx_q] + 32'd1,
					hops_q[idx_q], FLAG_INVALID, st_q[idx_q], 1'b1, 1'b0, !later);
			end else if (last_slot && !any_q) begin
				strobe_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			strobe <= 1'b0;
			idx_q <= '0;
			any_q <= 1'b0;
		end else begin
			strobe <= strobe_d;
			if (cmd.load) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end
			if (cmd.do_op) begin
				if (r_q.req_type == REQ_INSERT && !found && has_free) used_q[fidx] <= 1'b1;
				if (r_q.req_type == REQ_REMOVE && found) used_q[midx] <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (cur_match) any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
		rsp <= rsp_d;
		if (cmd.do_op) begin
			case (r_q.req_type)
				REQ_INSERT: begin
					if (found) begin
						if (ovw) begin
							seq_q[midx] <= r_q.seq_num;
							hops_q[midx] <= r_q.hop_count;
							flag_q[midx] <= r_q.route_flag;
							nh_q[midx] <= nkey;
							st_q[midx] <= r_q.route_state;
						end
					end else if (has_free) begin
						dest_q[fidx] <= dkey;
						seq_q[fidx] <= r_q.seq_num;
						hops_q[fidx] <= r_q.hop_count;
						flag_q[fidx] <= r_q.route_flag;
						nh_q[fidx] <= nkey;
						st_q[fidx] <= r_q.route_state;
					end
				end
				REQ_RAISE_SEQ: begin
					if (found && seq_q[midx] < r_q.seq_num) seq_q[midx] <= r_q.seq_num;
				end
				default: ;
			endcase
		end
		if (cmd.scan_step && cur_match) begin
			flag_q[idx_q] <= FLAG_INVALID;
			seq_q[idx_q] <= seq_q[idx_q] + 32'd1;
		end
	end

endmodule

// ===== rtl/art_ctrl.sv =====
module art_ctrl import art_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_OP;
				end
			end
			ST_OP: begin
				if (sts.is_scan) begin
					state_d = ST_SCAN;
				end else begin
					cmd.do_op = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/aodv_route_table.sv =====
// Route table, 16 slots, all matched in parallel.
// Insert, lookup, remove, raise_seq: run in the op state; start is ignored while busy.
// Link failure: scans one slot per cycle, one result per hit, or one empty result if none.
// Results cannot be stalled. Reset is asynchronous, active low, and clears all slots.
module aodv_route_table import art_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input req_t req,
	output logic strobe,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	art_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	art_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.strobe(strobe), .rsp(rsp)
	);

endmodule
